// ----- design/mbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared constants and types of the main bus decoder: address map, RAM
// geometry and the access descriptor passed from the decoder to the core.
// ----------------------------------------------------------------------------
package mbd_pkg;

	// Work RAM size in bytes; a power of two from 256 to 2048
	localparam int WORK_BYTES = 2048;
	localparam int WORK_AW    = $clog2(WORK_BYTES);
	localparam int VRAM_AW    = 10;
	localparam int CLR_AW     = (WORK_AW > VRAM_AW) ? WORK_AW : VRAM_AW;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_FETCH = 2'd2;

	localparam logic [15:0] ADDR_ROM      = 16'hA000;
	localparam logic [15:0] ADDR_WORK_END = 16'h0800;
	localparam logic [15:0] ADDR_SW_ONE   = 16'h1000;
	localparam logic [15:0] ADDR_SW_TWO   = 16'h1001;
	localparam logic [15:0] ADDR_PLAYER   = 16'h1002;
	localparam logic [15:0] ADDR_SPARE    = 16'h1003;
	localparam logic [15:0] ADDR_SYSTEM   = 16'h1004;
	localparam logic [15:0] ADDR_VIDEO    = 16'h4000;
	localparam logic [15:0] ADDR_COLOR    = 16'h4400;
	localparam logic [15:0] ADDR_VIDEO_SW = 16'h4800;
	localparam logic [15:0] ADDR_COLOR_SW = 16'h4C00;
	localparam logic [15:0] ADDR_BG       = 16'h5000;
	localparam logic [15:0] ADDR_SCROLL0  = 16'h5400;
	localparam logic [15:0] ADDR_SCROLL1  = 16'h5800;
	localparam logic [15:0] ADDR_PALETTE  = 16'h5C00;

	localparam logic [7:0] BYTE_OPEN = 8'hFF;
	localparam logic [7:0] KEEP_MASK = 8'h9F;

	localparam logic CFG_SW_ONE = 1'b0;
	localparam logic CFG_SW_TWO = 1'b1;

	typedef enum logic [2:0] {
		RSEL_IO,
		RSEL_WORK,
		RSEL_VIDEO,
		RSEL_COLOR,
		RSEL_BG
	} rsel_t;

	typedef struct packed {
		logic                work_we;
		logic                video_we;
		logic                color_we;
		logic                bg_we;
		logic [WORK_AW-1:0]  work_addr;
		logic [VRAM_AW-1:0]  video_addr;
		logic [VRAM_AW-1:0]  color_addr;
		logic [VRAM_AW-1:0]  bg_addr;
		rsel_t               rsel;
		logic                fetch;
		logic [7:0]          io_byte;
		logic                latch_we;
		logic                scroll0_we;
		logic                scroll1_we;
		logic                pal_we;
		logic [3:0]          pal_index;
	} acc_t;

	typedef struct packed {
		rsel_t      rsel;
		logic       fetch;
		logic [7:0] io_byte;
		logic       irq;
		logic [7:0] latch;
		logic       pst;
		logic [3:0] pidx;
		logic [7:0] pval;
		logic [7:0] scroll0;
		logic [7:0] scroll1;
	} stage_t;

	// Row/column swap of a 32x32 tile window
	function automatic logic [VRAM_AW-1:0] swap_rc(input logic [VRAM_AW-1:0] off);
		return {off[4:0], off[9:5]};
	endfunction

	// Exchange data bits 5 and 6
	function automatic logic [7:0] swap_bits56(input logic [7:0] v);
		return (v & KEEP_MASK) | {1'b0, v[5], v[6], 5'b0};
	endfunction

endpackage
`default_nettype wire

// ----- design/mbd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mbd_ram #(
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ----- design/mbd_decode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_decode
// Address decoder: turns one bus transaction into RAM enables and addresses,
// register write strobes and the byte of any non-RAM read source.
// ----------------------------------------------------------------------------
module mbd_decode
	import mbd_pkg::*;
(
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  rom_data,
	input  wire logic [6:0]  buttons,
	input  wire logic        vblank,
	input  wire logic [6:0]  sw_one,
	input  wire logic [7:0]  sw_two,
	output acc_t             acc
);

	logic               is_rd;
	logic               is_wr;
	logic               in_work;
	logic               in_video;
	logic               in_color;
	logic               in_video_sw;
	logic               in_color_sw;
	logic               in_bg;
	logic [VRAM_AW-1:0] off;

	always_comb begin
		is_rd       = (operation == OP_READ) || (operation == OP_FETCH);
		is_wr       = (operation == OP_WRITE);
		off         = address[VRAM_AW-1:0];
		in_work     = address < ADDR_WORK_END;
		in_video    = address[15:10] == ADDR_VIDEO[15:10];
		in_color    = address[15:10] == ADDR_COLOR[15:10];
		in_video_sw = address[15:10] == ADDR_VIDEO_SW[15:10];
		in_color_sw = address[15:10] == ADDR_COLOR_SW[15:10];
		in_bg       = address[15:10] == ADDR_BG[15:10];

		acc            = '0;
		acc.rsel       = RSEL_IO;
		acc.fetch      = (operation == OP_FETCH);
		acc.work_addr  = address[WORK_AW-1:0];
		acc.video_addr = in_video_sw ? swap_rc(off) : off;
		acc.color_addr = in_color_sw ? swap_rc(off) : off;
		acc.bg_addr    = off;
		acc.pal_index  = address[3:0];

		if (is_rd) begin
			acc.io_byte = BYTE_OPEN;
			if (address >= ADDR_ROM) begin
				acc.io_byte = rom_data;
			end else if (in_work) begin
				acc.rsel = RSEL_WORK;
			end else if (address == ADDR_SW_ONE) begin
				acc.io_byte = {vblank, sw_one};
			end else if (address == ADDR_SW_TWO) begin
				acc.io_byte = sw_two;
			end else if (address == ADDR_PLAYER) begin
				acc.io_byte = {3'b111, ~buttons[4:0]};
			end else if (address == ADDR_SPARE) begin
				acc.io_byte = BYTE_OPEN;
			end else if (address == ADDR_SYSTEM) begin
				acc.io_byte = {1'b1, ~buttons[6], 2'b11, ~buttons[5], 3'b111};
			end else if (in_video || in_video_sw) begin
				acc.rsel = RSEL_VIDEO;
			end else if (in_color || in_color_sw) begin
				acc.rsel = RSEL_COLOR;
			end else if (in_bg) begin
				acc.rsel = RSEL_BG;
			end
		end

		if (is_wr) begin
			acc.work_we    = in_work;
			acc.latch_we   = address == ADDR_PLAYER;
			acc.video_we   = in_video || in_video_sw;
			acc.color_we   = in_color || in_color_sw;
			acc.bg_we      = in_bg;
			acc.scroll0_we = address == ADDR_SCROLL0;
			acc.scroll1_we = address == ADDR_SCROLL1;
			acc.pal_we     = address[15:4] == ADDR_PALETTE[15:4];
		end
	end

endmodule
`default_nettype wire

// ----- design/main_bus_decoder_with_opcode_bitswap_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// main_bus_decoder_with_opcode_bitswap_core
// Main CPU bus memory map with work/video/color/background RAM, switch and
// joystick ports, sound latch, scroll registers and palette write port.
//
// Input channel (in_valid/in_stall) carries one bus transaction: operation,
// address, write data, the ROM byte at that address, buttons and vblank.
// Output channel (out_valid/out_stall) returns one result per transaction.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) loads
// the two switch bytes; it is always ready.
// Acceptance runs the RAM access and captures the decoded transaction in
// stage one; the output register then takes the result. One transaction is
// accepted every cycle while in_stall is low, bounded by the single RAM
// port of each memory.
// After reset the four RAMs are cleared, one entry per cycle in parallel,
// while a counter steps through every address of the largest RAM; in_stall
// is high until the clear ends. When the receiver stalls, the result holds,
// the stage behind it fills, and then in_stall is raised.
// ----------------------------------------------------------------------------
module main_bus_decoder_with_opcode_bitswap_core
	import mbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic [7:0]  rom_data,
	input  wire logic [6:0]  buttons,
	input  wire logic        vblank,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       read_data,
	output logic             sound_irq_raise,
	output logic [7:0]       latch_value,
	output logic             palette_strobe,
	output logic [3:0]       palette_index,
	output logic [7:0]       palette_value,
	output logic [7:0]       scroll_first,
	output logic [7:0]       scroll_second,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	acc_t              acc;
	stage_t            stage_s1;
	stage_t            stage_d;
	logic              valid_s1;
	logic              adv_s1;
	logic              accept;
	logic              clr_busy_q;
	logic [CLR_AW-1:0] clr_cnt_q;
	logic [6:0]        sw_one_q;
	logic [7:0]        sw_two_q;
	logic [7:0]        latch_q;
	logic [7:0]        scroll0_q;
	logic [7:0]        scroll1_q;
	logic [7:0]        latch_d;
	logic [7:0]        scroll0_d;
	logic [7:0]        scroll1_d;
	logic              ram_en;
	logic [7:0]        ram_wdata;
	logic [7:0]        work_rd;
	logic [7:0]        video_rd;
	logic [7:0]        color_rd;
	logic [7:0]        bg_rd;
	logic [7:0]        rd_mux;

	mbd_decode u_decode (
		.operation (operation),
		.address   (address),
		.rom_data  (rom_data),
		.buttons   (buttons),
		.vblank    (vblank),
		.sw_one    (sw_one_q),
		.sw_two    (sw_two_q),
		.acc       (acc)
	);

	assign adv_s1    = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = clr_busy_q || (valid_s1 && !adv_s1);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign ram_en    = clr_busy_q || accept;
	assign ram_wdata = clr_busy_q ? 8'h00 : write_data;

	mbd_ram #(.AW(WORK_AW)) u_work (
		.clk   (clk),
		.en    (ram_en),
		.we    (clr_busy_q || acc.work_we),
		.addr  (clr_busy_q ? clr_cnt_q[WORK_AW-1:0] : acc.work_addr),
		.wdata (ram_wdata),
		.rdata (work_rd)
	);

	mbd_ram #(.AW(VRAM_AW)) u_video (
		.clk   (clk),
		.en    (ram_en),
		.we    (clr_busy_q || acc.video_we),
		.addr  (clr_busy_q ? clr_cnt_q[VRAM_AW-1:0] : acc.video_addr),
		.wdata (ram_wdata),
		.rdata (video_rd)
	);

	mbd_ram #(.AW(VRAM_AW)) u_color (
		.clk   (clk),
		.en    (ram_en),
		.we    (clr_busy_q || acc.color_we),
		.addr  (clr_busy_q ? clr_cnt_q[VRAM_AW-1:0] : acc.color_addr),
		.wdata (ram_wdata),
		.rdata (color_rd)
	);

	mbd_ram #(.AW(VRAM_AW)) u_bg (
		.clk   (clk),
		.en    (ram_en),
		.we    (clr_busy_q || acc.bg_we),
		.addr  (clr_busy_q ? clr_cnt_q[VRAM_AW-1:0] : acc.bg_addr),
		.wdata (ram_wdata),
		.rdata (bg_rd)
	);

	always_comb begin
		latch_d   = acc.latch_we ? write_data : latch_q;
		scroll0_d = acc.scroll0_we ? write_data : scroll0_q;
		scroll1_d = acc.scroll1_we ? write_data : scroll1_q;

		stage_d         = '0;
		stage_d.rsel    = acc.rsel;
		stage_d.fetch   = acc.fetch;
		stage_d.io_byte = acc.io_byte;
		stage_d.irq     = acc.latch_we;
		stage_d.latch   = latch_d;
		stage_d.pst     = acc.pal_we;
		stage_d.pidx    = acc.pal_we ? acc.pal_index : 4'd0;
		stage_d.pval    = acc.pal_we ? write_data : 8'd0;
		stage_d.scroll0 = scroll0_d;
		stage_d.scroll1 = scroll1_d;
	end

	always_comb begin
		case (stage_s1.rsel)
			RSEL_IO:    rd_mux = stage_s1.io_byte;
			RSEL_WORK:  rd_mux = work_rd;
			RSEL_VIDEO: rd_mux = video_rd;
			RSEL_COLOR: rd_mux = color_rd;
			RSEL_BG:    rd_mux = bg_rd;
			default:    rd_mux = BYTE_OPEN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			sw_one_q   <= '0;
			sw_two_q   <= '0;
			latch_q    <= '0;
			scroll0_q  <= '0;
			scroll1_q  <= '0;
			valid_s1   <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (&clr_cnt_q) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SW_ONE: sw_one_q <= cfg_data[6:0];
					CFG_SW_TWO: sw_two_q <= cfg_data;
					default:    sw_two_q <= sw_two_q;
				endcase
			end
			if (accept) begin
				latch_q   <= latch_d;
				scroll0_q <= scroll0_d;
				scroll1_q <= scroll1_d;
				valid_s1  <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= stage_d;
		end
		if (adv_s1) begin
			read_data       <= stage_s1.fetch ? swap_bits56(rd_mux) : rd_mux;
			sound_irq_raise <= stage_s1.irq;
			latch_value     <= stage_s1.latch;
			palette_strobe  <= stage_s1.pst;
			palette_index   <= stage_s1.pidx;
			palette_value   <= stage_s1.pval;
			scroll_first    <= stage_s1.scroll0;
			scroll_second   <= stage_s1.scroll1;
		end
	end

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!valid_s1 && !out_valid))
		else $error("pipeline holds a transaction during RAM clear");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && out_stall) |-> in_stall)
		else $error("input accepted while both stages are blocked");

	a_pal_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && palette_strobe) |-> (read_data == 8'h00 && !sound_irq_raise))
		else $error("palette write result carries read data or irq");

	a_irq_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && acc.latch_we) |=> (stage_s1.irq && stage_s1.latch == $past(write_data)))
		else $error("sound latch write not captured");

endmodule
`default_nettype wire
